[design/drts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package drts_pkg;

  localparam int DEF_MAX_SCHEDULES = 16;
  localparam int DEF_RELAY_COUNT   = 8;

  localparam int TKEY_W = 11;

  // command codes
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_SYNC   = 2'd3;

  // report kinds
  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_ON   = 2'd1;
  localparam logic [1:0] ACT_OFF  = 2'd2;

  typedef struct packed {
    logic [2:0] relay;
    logic [4:0] on_h;
    logic [5:0] on_m;
    logic [4:0] off_h;
    logic [5:0] off_m;
  } sched_t;

  typedef struct packed {
    logic [1:0] report_kind;
    logic [1:0] status;
    logic [3:0] entry_slot;
    logic [2:0] relay_out;
    logic [1:0] action;
    logic       relay_on;
    logic       last;
  } report_t;

  typedef struct packed {
    logic       now_on;
    logic [1:0] action;
  } eval_t;

endpackage

`default_nettype wire

[design/drts_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface drts_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [2:0] relay_id;
  logic [4:0] start_hour;
  logic [5:0] start_minute;
  logic [4:0] stop_hour;
  logic [5:0] stop_minute;
  logic [3:0] remove_slot;
  logic [4:0] now_hour;
  logic [5:0] now_minute;

  modport source (
    output valid, func, relay_id, start_hour, start_minute, stop_hour, stop_minute,
           remove_slot, now_hour, now_minute,
    input  ready
  );
  modport sink (
    input  valid, func, relay_id, start_hour, start_minute, stop_hour, stop_minute,
           remove_slot, now_hour, now_minute,
    output ready
  );
endinterface

interface drts_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] report_kind;
  logic [1:0] status;
  logic [3:0] entry_slot;
  logic [2:0] relay_out;
  logic [1:0] action;
  logic       relay_on;
  logic       last;

  modport source (
    output valid, report_kind, status, entry_slot, relay_out, action, relay_on, last,
    input  ready
  );
  modport sink (
    input  valid, report_kind, status, entry_slot, relay_out, action, relay_on, last,
    output ready
  );
endinterface

`default_nettype wire

[design/daily_relay_time_switch_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Daily relay time switch: a compacted table of on/off schedules, one per entry, held in
// a single-port-read RAM and walked by a small sequencer around one shared evaluator.
// Add, and any rejected command, offers its acknowledge in the cycle after acceptance.
// Tick and sync take each table entry through RAM read, evaluate and present result,
// waiting for each result transfer; an empty table answers at once. Remove reads the
// entry to be removed, then moves each entry above it down one place; each move is a
// RAM read followed by a RAM write. No new command is taken until the last result of
// the current one has been transferred. The table needs no clearing after reset: only
// entries below the fill count are ever read.
module daily_relay_time_switch_unit
  import drts_pkg::*;
#(
  parameter int MAX_SCHEDULES = DEF_MAX_SCHEDULES,
  parameter int RELAY_COUNT   = DEF_RELAY_COUNT
) (
  input wire logic  clk,
  input wire logic  rst,
  drts_req_if.sink  req,
  drts_rsp_if.source rsp
);

  localparam int IDX_W = (MAX_SCHEDULES > 1) ? $clog2(MAX_SCHEDULES) : 1;
  localparam int CNT_W = $clog2(MAX_SCHEDULES + 1);
  localparam int SLC_W = (CNT_W > 4) ? CNT_W : 4;
  localparam int SL_W  = (IDX_W > 4) ? IDX_W : 4;
  localparam int ENT_W = $bits(sched_t);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD     = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_OUT    = 3'd3;
  localparam logic [2:0] S_RM_RD  = 3'd4;
  localparam logic [2:0] S_RM_CAP = 3'd5;
  localparam logic [2:0] S_SH_RD  = 3'd6;
  localparam logic [2:0] S_SH_WR  = 3'd7;

  logic [2:0]               state;
  logic [IDX_W-1:0]         idx;
  logic [CNT_W-1:0]         count;
  logic [MAX_SCHEDULES-1:0] flags;
  logic                     sync_q;
  logic [TKEY_W-1:0]        now_q;
  logic [2:0]               rm_relay;
  logic                     rm_was;
  report_t                  rep;
  report_t                  ack_rep;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;
  sched_t           ent;
  sched_t           new_ent;
  eval_t            ev;

  logic             in_xfer;
  logic             out_xfer;
  logic             add_ok;
  logic             rid_bad;
  logic             full;
  logic [SLC_W-1:0] slot_ext;
  logic [CNT_W-1:0] idx1;
  logic [CNT_W:0]   idx2;
  logic [SL_W-1:0]  idx_sl;
  logic [SL_W-1:0]  cnt_sl;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign in_xfer   = req.valid && req.ready;
  assign out_xfer  = rsp.valid && rsp.ready;

  assign rsp.report_kind = rep.report_kind;
  assign rsp.status      = rep.status;
  assign rsp.entry_slot  = rep.entry_slot;
  assign rsp.relay_out   = rep.relay_out;
  assign rsp.action      = rep.action;
  assign rsp.relay_on    = rep.relay_on;
  assign rsp.last        = rep.last;

  assign rid_bad  = 32'(req.relay_id) >= 32'(RELAY_COUNT);
  assign full     = 32'(count) >= 32'(MAX_SCHEDULES);
  assign add_ok   = !rid_bad && !full;
  assign slot_ext = SLC_W'(req.remove_slot);
  assign idx1     = CNT_W'(idx) + CNT_W'(1);
  assign idx2     = (CNT_W + 1)'(idx1) + (CNT_W + 1)'(1);
  assign idx_sl   = SL_W'(idx);
  assign cnt_sl   = SL_W'(count);
  assign ent      = sched_t'(ram_rdata);

  always_comb begin
    new_ent.relay = req.relay_id;
    new_ent.on_h  = req.start_hour;
    new_ent.on_m  = req.start_minute;
    new_ent.off_h = req.stop_hour;
    new_ent.off_m = req.stop_minute;
  end

  // acknowledge or empty-table result of an incoming command
  always_comb begin
    ack_rep = '{KIND_ACK, ST_OK, 4'd0, 3'd0, ACT_NONE, 1'b0, 1'b1};
    case (req.func)
      FUNC_ADD: begin
        ack_rep.relay_out = req.relay_id;
        if (rid_bad) begin
          ack_rep.status = ST_BAD;
        end else if (full) begin
          ack_rep.status = ST_FULL;
        end else begin
          ack_rep.entry_slot = cnt_sl[3:0];
        end
      end
      FUNC_REMOVE: begin
        ack_rep.entry_slot = req.remove_slot;
        if (slot_ext >= SLC_W'(count)) begin
          ack_rep.status = ST_BAD;
        end
      end
      default: begin
        if (count == '0) begin
          ack_rep.report_kind = KIND_EMPTY;
        end
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[IDX_W-1:0];
    ram_wdata = new_ent;
    ram_raddr = idx;
    case (state)
      S_IDLE: begin
        ram_we = in_xfer && (req.func == FUNC_ADD) && add_ok;
      end
      S_SH_RD: begin
        ram_raddr = idx1[IDX_W-1:0];
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  drts_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_SCHEDULES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  drts_eval u_eval (
    .sync_mode (sync_q),
    .now_key   (now_q),
    .entry     (ent),
    .was_on    (flags[idx]),
    .res       (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      flags <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            sync_q <= (req.func == FUNC_SYNC);
            now_q  <= {req.now_hour, req.now_minute};
            rep    <= ack_rep;
            case (req.func)
              FUNC_ADD: begin
                if (add_ok) begin
                  flags[count[IDX_W-1:0]] <= 1'b0;
                  count                   <= count + CNT_W'(1);
                end
                state <= S_OUT;
              end
              FUNC_REMOVE: begin
                if (slot_ext >= SLC_W'(count)) begin
                  state <= S_OUT;
                end else begin
                  idx   <= slot_ext[IDX_W-1:0];
                  state <= S_RM_RD;
                end
              end
              default: begin
                if (count == '0) begin
                  state <= S_OUT;
                end else begin
                  idx   <= '0;
                  state <= S_RD;
                end
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          flags[idx] <= ev.now_on;
          rep        <= '{KIND_REPORT, ST_OK, idx_sl[3:0], ent.relay, ev.action,
                          ev.now_on, (idx1 == count)};
          state      <= S_OUT;
        end
        S_OUT: begin
          if (out_xfer) begin
            if (rep.report_kind == KIND_REPORT && !rep.last) begin
              idx   <= idx1[IDX_W-1:0];
              state <= S_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_RM_RD: begin
          state <= S_RM_CAP;
        end
        S_RM_CAP: begin
          rm_relay <= ent.relay;
          rm_was   <= flags[idx];
          if (idx1 < count) begin
            state <= S_SH_RD;
          end else begin
            rep   <= '{KIND_ACK, ST_OK, rep.entry_slot, ent.relay, ACT_NONE, flags[idx],
                       1'b1};
            count <= count - CNT_W'(1);
            state <= S_OUT;
          end
        end
        S_SH_RD: begin
          state <= S_SH_WR;
        end
        S_SH_WR: begin
          // entry above moves down one place together with its flag
          flags[idx] <= flags[idx1[IDX_W-1:0]];
          idx        <= idx1[IDX_W-1:0];
          if (idx2 < (CNT_W + 1)'(count)) begin
            state <= S_SH_RD;
          end else begin
            rep   <= '{KIND_ACK, ST_OK, rep.entry_slot, rm_relay, ACT_NONE, rm_was, 1'b1};
            count <= count - CNT_W'(1);
            state <= S_OUT;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/drts_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module drts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/drts_eval.sv]
`timescale 1ns / 1ps
`default_nettype none

module drts_eval
  import drts_pkg::*;
(
  input  wire logic              sync_mode,
  input  wire logic [TKEY_W-1:0] now_key,
  input  wire sched_t            entry,
  input  wire logic              was_on,
  output eval_t                  res
);

  logic [TKEY_W-1:0] ton;
  logic [TKEY_W-1:0] toff;
  logic              on_next;

  assign ton  = {entry.on_h, entry.on_m};
  assign toff = {entry.off_h, entry.off_m};

  always_comb begin
    on_next = was_on;
    if (sync_mode) begin
      // window wraps past midnight when the off time is not after the on time
      if (ton < toff) begin
        on_next = (now_key >= ton) && (now_key < toff);
      end else begin
        on_next = (now_key >= ton) || (now_key < toff);
      end
    end else if (now_key == ton && !was_on) begin
      on_next = 1'b1;
    end else if (now_key == toff && was_on) begin
      on_next = 1'b0;
    end
    res.now_on = on_next;
    if (on_next && !was_on) begin
      res.action = ACT_ON;
    end else if (!on_next && was_on) begin
      res.action = ACT_OFF;
    end else begin
      res.action = ACT_NONE;
    end
  end

endmodule

`default_nettype wire

[dv/drts_checker.sv]
`timescale 1ns / 1ps

module drts_checker
  import drts_pkg::*;
#(
  parameter int MAX_SCHEDULES = DEF_MAX_SCHEDULES,
  parameter int RELAY_COUNT   = DEF_RELAY_COUNT
) (
  input wire logic clk,
  input wire logic rst,
  drts_req_if      req,
  drts_rsp_if      rsp,
  output int       mismatches,
  output int       outstanding
);

  localparam int EXP_DEPTH = 64;

  // predicted copy of the schedule table
  sched_t  sched_mem [MAX_SCHEDULES];
  logic    on_flag   [MAX_SCHEDULES];
  int      fill;
  report_t exp_fifo [EXP_DEPTH];
  int      wr_cnt;
  int      rd_cnt;

  function automatic report_t pack_report(logic [1:0] kind, logic [1:0] st, logic [3:0] slot,
                                          logic [2:0] relay, logic [1:0] act, logic on,
                                          logic is_last);
    report_t r;
    r.report_kind = kind;
    r.status      = st;
    r.entry_slot  = slot;
    r.relay_out   = relay;
    r.action      = act;
    r.relay_on    = on;
    r.last        = is_last;
    return r;
  endfunction

  task automatic add_expected(input report_t r);
    exp_fifo[wr_cnt[5:0]] = r;
    wr_cnt++;
  endtask

  // works out the reports of one accepted command and updates the table copy
  task automatic switch_table_step();
    sched_t      ent;
    logic [10:0] now_key;
    logic [10:0] on_key;
    logic [10:0] off_key;
    logic        was;
    logic        nxt;
    logic [1:0]  act;
    int          slot;
    now_key = {req.now_hour, req.now_minute};
    case (req.func)
      FUNC_ADD: begin
        if (int'(req.relay_id) >= RELAY_COUNT) begin
          add_expected(pack_report(KIND_ACK, ST_BAD, 4'd0, req.relay_id,
                                   ACT_NONE, 1'b0, 1'b1));
        end else if (fill >= MAX_SCHEDULES) begin
          add_expected(pack_report(KIND_ACK, ST_FULL, 4'd0, req.relay_id,
                                   ACT_NONE, 1'b0, 1'b1));
        end else begin
          ent = '{relay: req.relay_id, on_h: req.start_hour, on_m: req.start_minute,
                  off_h: req.stop_hour, off_m: req.stop_minute};
          sched_mem[fill] = ent;
          on_flag[fill] = 1'b0;
          add_expected(pack_report(KIND_ACK, ST_OK, 4'(fill), req.relay_id,
                                   ACT_NONE, 1'b0, 1'b1));
          fill++;
        end
      end
      FUNC_REMOVE: begin
        slot = int'(req.remove_slot);
        if (slot >= fill) begin
          add_expected(pack_report(KIND_ACK, ST_BAD, req.remove_slot, 3'd0,
                                   ACT_NONE, 1'b0, 1'b1));
        end else begin
          ent = sched_mem[slot];
          was = on_flag[slot];
          // close the gap, flags move with their entries
          for (int i = slot; i + 1 < fill; i++) begin
            sched_mem[i] = sched_mem[i + 1];
            on_flag[i] = on_flag[i + 1];
          end
          fill--;
          add_expected(pack_report(KIND_ACK, ST_OK, req.remove_slot, ent.relay,
                                   ACT_NONE, was, 1'b1));
        end
      end
      default: begin
        if (fill == 0) begin
          add_expected(pack_report(KIND_EMPTY, ST_OK, 4'd0, 3'd0, ACT_NONE,
                                   1'b0, 1'b1));
        end else begin
          for (int i = 0; i < fill; i++) begin
            on_key = {sched_mem[i].on_h, sched_mem[i].on_m};
            off_key = {sched_mem[i].off_h, sched_mem[i].off_m};
            was = on_flag[i];
            nxt = was;
            if (req.func == FUNC_TICK) begin
              if (now_key == on_key && !was) nxt = 1'b1;
              else if (now_key == off_key && was) nxt = 1'b0;
            end else if (on_key < off_key) begin
              nxt = (now_key >= on_key) && (now_key < off_key);
            end else begin
              // window wraps past midnight, equal times mean always on
              nxt = (now_key >= on_key) || (now_key < off_key);
            end
            if (nxt && !was) act = ACT_ON;
            else if (!nxt && was) act = ACT_OFF;
            else act = ACT_NONE;
            on_flag[i] = nxt;
            add_expected(pack_report(KIND_REPORT, ST_OK, 4'(i),
                                     sched_mem[i].relay, act, nxt,
                                     (i + 1 == fill)));
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst) begin
      for (int i = 0; i < MAX_SCHEDULES; i++) on_flag[i] = 1'b0;
      fill = 0;
      mismatches = 0;
      wr_cnt = 0;
      rd_cnt = 0;
    end else begin
      if (req.valid && req.ready) switch_table_step();
      if (rsp.valid && rsp.ready) begin
        got = '{report_kind: rsp.report_kind, status: rsp.status, entry_slot: rsp.entry_slot,
                relay_out: rsp.relay_out, action: rsp.action, relay_on: rsp.relay_on,
                last: rsp.last};
        if (wr_cnt == rd_cnt) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: unexpected report kind=%0d st=%0d slot=%0d relay=%0d",
                      " act=%0d on=%0d last=%0d"},
                     $realtime, got.report_kind, got.status, got.entry_slot, got.relay_out,
                     got.action, got.relay_on, got.last);
        end else begin
          want = exp_fifo[rd_cnt[5:0]];
          rd_cnt++;
          if (got.report_kind !== want.report_kind || got.status !== want.status ||
              got.entry_slot !== want.entry_slot || got.relay_out !== want.relay_out ||
              got.action !== want.action || got.relay_on !== want.relay_on ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: report mismatch", $realtime);
              $display("  exp kind=%0d st=%0d slot=%0d relay=%0d act=%0d on=%0d last=%0d",
                       want.report_kind, want.status, want.entry_slot, want.relay_out,
                       want.action, want.relay_on, want.last);
              $display("  got kind=%0d st=%0d slot=%0d relay=%0d act=%0d on=%0d last=%0d",
                       got.report_kind, got.status, got.entry_slot, got.relay_out,
                       got.action, got.relay_on, got.last);
            end
          end
        end
      end
    end
    outstanding = wr_cnt - rd_cnt;
  end

endmodule

[dv/tb_daily_relay_time_switch_unit.sv]
`timescale 1ns / 1ps

module tb_daily_relay_time_switch_unit
  import drts_pkg::*;
();

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 100;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] relay_id;
    logic [4:0] start_hour;
    logic [5:0] start_minute;
    logic [4:0] stop_hour;
    logic [5:0] stop_minute;
    logic [3:0] remove_slot;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
  } cmd_t;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_requests;
  int   table_fill;
  logic [10:0] time_pool [8];

  drts_req_if req ();
  drts_rsp_if rsp ();

  daily_relay_time_switch_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  drts_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(6_000_000);
    $display("daily_relay_time_switch_unit regression: fail");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int holds_served;
    holds_served = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_served++;
      end else begin
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic cmd_t make_cmd(logic [1:0] fn, logic [2:0] rid, logic [10:0] on_t,
                                    logic [10:0] off_t, logic [3:0] slot, logic [10:0] now_t);
    cmd_t c;
    c.func = fn;
    c.relay_id = rid;
    {c.start_hour, c.start_minute} = on_t;
    {c.stop_hour, c.stop_minute} = off_t;
    c.remove_slot = slot;
    {c.now_hour, c.now_minute} = now_t;
    return c;
  endfunction

  // times mostly come from a small pool so that ticks hit on and off times
  function automatic logic [10:0] pick_time();
    int r;
    r = $urandom_range(99);
    if (r < 55) return time_pool[$urandom_range(7)];
    if (r < 92) return {5'($urandom_range(23)), 6'($urandom_range(59))};
    return 11'($urandom_range(2047));
  endfunction

  function automatic cmd_t random_command(int add_pct, int remove_pct, int tick_pct);
    int   pick;
    logic [3:0] slot;
    pick = $urandom_range(99);
    if (table_fill > 0 && $urandom_range(99) < 85) slot = 4'($urandom_range(table_fill - 1));
    else slot = 4'($urandom_range(15));
    return make_cmd((pick < add_pct) ? FUNC_ADD :
                    (pick < add_pct + remove_pct) ? FUNC_REMOVE :
                    (pick < add_pct + remove_pct + tick_pct) ? FUNC_TICK : FUNC_SYNC,
                    3'($urandom_range(7)), pick_time(), pick_time(), slot, pick_time());
  endfunction

  task automatic send_command(input cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid        <= 1'b1;
    req.func         <= c.func;
    req.relay_id     <= c.relay_id;
    req.start_hour   <= c.start_hour;
    req.start_minute <= c.start_minute;
    req.stop_hour    <= c.stop_hour;
    req.stop_minute  <= c.stop_minute;
    req.remove_slot  <= c.remove_slot;
    req.now_hour     <= c.now_hour;
    req.now_minute   <= c.now_minute;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    // follow the fill level so removes mostly aim at live entries
    if (c.func == FUNC_ADD && table_fill < DEF_MAX_SCHEDULES) table_fill++;
    else if (c.func == FUNC_REMOVE && int'(c.remove_slot) < table_fill) table_fill--;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    req.valid <= 1'b0;
    while (outstanding != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
  endtask

  task automatic run_phase(int n, int idle, int stall, int add_pct, int remove_pct,
                           int tick_pct, bit hold_mid);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 3) hold_requests++;
      send_command(random_command(add_pct, remove_pct, tick_pct));
    end
  endtask

  initial begin
    rst = 1'b1;
    hold_requests = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    table_fill = 0;
    req.valid = 1'b0;
    req.func = FUNC_ADD;
    req.relay_id = '0;
    req.start_hour = '0;
    req.start_minute = '0;
    req.stop_hour = '0;
    req.stop_minute = '0;
    req.remove_slot = '0;
    req.now_hour = '0;
    req.now_minute = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table cases
    send_command(make_cmd(FUNC_TICK, 3'd0, 11'd0, 11'd0, 4'd0, {5'd0, 6'd0}));
    send_command(make_cmd(FUNC_SYNC, 3'd7, 11'd0, 11'd0, 4'd15, {5'd31, 6'd63}));
    send_command(make_cmd(FUNC_REMOVE, 3'd0, 11'd0, 11'd0, 4'd0, 11'd0));
    // plain window, wrapping window, always on, never-matching on time, full day
    send_command(make_cmd(FUNC_ADD, 3'd0, {5'd8, 6'd30}, {5'd17, 6'd45}, 4'd0, 11'd0));
    send_command(make_cmd(FUNC_ADD, 3'd7, {5'd22, 6'd0}, {5'd6, 6'd15}, 4'd0, 11'd0));
    send_command(make_cmd(FUNC_ADD, 3'd3, {5'd12, 6'd0}, {5'd12, 6'd0}, 4'd0, 11'd0));
    send_command(make_cmd(FUNC_ADD, 3'd5, {5'd31, 6'd63}, {5'd0, 6'd0}, 4'd0, 11'd0));
    send_command(make_cmd(FUNC_ADD, 3'd2, {5'd0, 6'd0}, {5'd23, 6'd59}, 4'd0, 11'd0));
    send_command(make_cmd(FUNC_TICK, 3'd0, 11'd0, 11'd0, 4'd0, {5'd8, 6'd30}));
    send_command(make_cmd(FUNC_TICK, 3'd0, 11'd0, 11'd0, 4'd0, {5'd8, 6'd30}));
    send_command(make_cmd(FUNC_TICK, 3'd0, 11'd0, 11'd0, 4'd0, {5'd17, 6'd45}));
    // equal on and off: first tick switches on, second switches off
    send_command(make_cmd(FUNC_TICK, 3'd0, 11'd0, 11'd0, 4'd0, {5'd12, 6'd0}));
    send_command(make_cmd(FUNC_TICK, 3'd0, 11'd0, 11'd0, 4'd0, {5'd12, 6'd0}));
    send_command(make_cmd(FUNC_SYNC, 3'd0, 11'd0, 11'd0, 4'd0, {5'd23, 6'd0}));
    send_command(make_cmd(FUNC_SYNC, 3'd0, 11'd0, 11'd0, 4'd0, {5'd12, 6'd0}));
    send_command(make_cmd(FUNC_SYNC, 3'd0, 11'd0, 11'd0, 4'd0, {5'd31, 6'd63}));
    send_command(make_cmd(FUNC_REMOVE, 3'd0, 11'd0, 11'd0, 4'd1, 11'd0));
    send_command(make_cmd(FUNC_REMOVE, 3'd0, 11'd0, 11'd0, 4'd15, 11'd0));
    send_command(make_cmd(FUNC_REMOVE, 3'd0, 11'd0, 11'd0, 4'd3, 11'd0));
    send_command(make_cmd(FUNC_SYNC, 3'd0, 11'd0, 11'd0, 4'd0, {5'd0, 6'd0}));
    send_command(make_cmd(FUNC_TICK, 3'd0, 11'd0, 11'd0, 4'd0, {5'd0, 6'd0}));

    time_pool[0] = {5'd0, 6'd0};
    time_pool[1] = {5'd23, 6'd59};
    for (int i = 2; i < 8; i++) time_pool[i] = {5'($urandom_range(23)), 6'($urandom_range(59))};

    // fill the table past full while the result side holds off for a while
    run_phase(60, 0, 0, 60, 10, 20, 1'b1);
    run_phase(70, 65, 0, 30, 25, 30, 1'b0);
    run_phase(70, 0, 65, 15, 45, 25, 1'b0);
    wait_drained();
    run_phase(60, 7, 7, 45, 15, 25, 1'b0);
    run_phase(40, 0, 0, 10, 60, 15, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("daily_relay_time_switch_unit regression: pass");
    end else begin
      if (outstanding != 0) $display("%0d expected reports never arrived", outstanding);
      $display("daily_relay_time_switch_unit regression: fail");
    end
    $finish;
  end

endmodule
